// ===== design/closest_pair_of_points_macros.svh =====
// ----------------------------------------------------------------------------
// closest pair of points assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_OF_POINTS_MACROS_SVH
`define CLOSEST_PAIR_OF_POINTS_MACROS_SVH

// cons must hold in the same cycle as ante
`define CPOP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define CPOP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cpop_pkg.sv =====
// ----------------------------------------------------------------------------
// cpop_pkg
// sizes, point and result types shared by the closest pair search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpop_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int NUM_CELLS  = 16;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int COORD_W = 31;
    localparam int ID_W    = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    // lets the last compare of a batch settle after the stream ends
    localparam int DRAIN_LEN = NUM_CELLS + 4;
    localparam int PHASE_W   = $clog2(DRAIN_LEN);

    localparam int IN_FIELDS_W  = 2 * COORD_W + ID_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DIST_W + 2 * ID_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           id;
    } cpop_point_t;

    typedef struct packed {
        logic        valid;
        logic        taken;
        cpop_point_t pt;
    } cpop_stream_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id_a;
        logic [ID_W-1:0]   id_b;
    } cpop_best_t;

endpackage

`default_nettype wire

// ===== design/closest_pair_of_points.sv =====
// ----------------------------------------------------------------------------
// closest_pair_of_points
// Points (x, y, id) load one per cycle into a 1024-entry point memory until
// a transaction with tlast closes the set; a row of 16 search cells then finds
// the pair with the least squared distance, ties going to the earliest pair in
// (earlier, later) index order, and one result transaction follows. A set of n
// points is searched in ceil((n-1)/16) batches; the batch starting at index b
// streams the n-b points from b upward past the cells at one memory read per
// cycle, followed by the cell pipeline drain and the walk of the partial results
// down the row. Loading goes on while a finished result still waits on
// m_tready; s_tready is low during a search. Points beyond 1024 are dropped;
// fewer than two points give pair_found 0 with zero fields. The point memory
// needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "closest_pair_of_points_macros.svh"

module closest_pair_of_points (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x_coord[30:0], y_coord[61:31], point_id[77:62], zero pad
    input  logic [cpop_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // min_sq_dist[62:0], first_id[78:63], second_id[94:79], zero pad
    output logic [cpop_pkg::OUT_DATA_W-1:0]  m_tdata,
    // pair_found[0]
    output logic                             m_tuser
);
    import cpop_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_STREAM = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_REDUCE = 5'b01000,
        ST_EMIT   = 5'b10000
    } cpop_state_t;

    cpop_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic              rd_valid_reg;
    cpop_best_t        global_reg, global_next;
    logic              out_valid_reg, out_valid_next;
    cpop_best_t        out_best_reg, out_best_next;

    logic              in_accept;
    logic              wr_en;
    logic              rd_en;
    logic              clear_cells;
    logic [CNT_W-1:0]  counted;
    logic [CNT_W:0]    base_sum;
    cpop_point_t       in_pt;
    cpop_point_t       rd_pt;

    cpop_stream_t      stream_link [NUM_CELLS+1];
    cpop_best_t        red_link    [NUM_CELLS+1];

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_LOAD);

    assign in_pt.x  = s_tdata[COORD_W-1:0];
    assign in_pt.y  = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pt.id = s_tdata[IN_FIELDS_W-1:2*COORD_W];

    // a full store drops the point but still honors tlast
    assign wr_en    = in_accept && (count_reg < CNT_W'(MAX_POINTS));
    assign counted  = wr_en ? count_reg + CNT_W'(1) : count_reg;
    assign base_sum = {1'b0, base_reg} + (CNT_W+1)'(NUM_CELLS);
    assign rd_en    = (state_reg == ST_STREAM);

    cpop_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (in_pt),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_pt)
    );

    assign stream_link[0].valid = rd_valid_reg;
    assign stream_link[0].taken = 1'b0;
    assign stream_link[0].pt    = rd_pt;
    assign red_link[0]          = global_reg;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cpop_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear      (clear_cells),
            .stream_in  (stream_link[k]),
            .stream_out (stream_link[k+1]),
            .red_in     (red_link[k]),
            .red_out    (red_link[k+1])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        rd_idx_next    = rd_idx_reg;
        phase_next     = phase_reg;
        global_next    = global_reg;
        out_valid_next = out_valid_reg;
        out_best_next  = out_best_reg;
        clear_cells    = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_accept) begin
                    count_next = counted;
                    if (s_tlast) begin
                        count_next  = '0;
                        n_next      = counted;
                        base_next   = '0;
                        rd_idx_next = '0;
                        global_next = '0;
                        if (counted > CNT_W'(1)) begin
                            clear_cells = 1'b1;
                            state_next  = ST_STREAM;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_STREAM: begin
                if (rd_idx_reg == n_reg - CNT_W'(1)) begin
                    phase_next = '0;
                    state_next = ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (phase_reg == PHASE_W'(DRAIN_LEN - 1)) begin
                    phase_next = '0;
                    state_next = ST_REDUCE;
                end else begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            ST_REDUCE: begin
                phase_next = phase_reg + PHASE_W'(1);
                // the end of the row holds the batch result once the partial results have walked the row
                if (phase_reg == PHASE_W'(NUM_CELLS)) begin
                    global_next = red_link[NUM_CELLS].found ? red_link[NUM_CELLS] : '0;
                    if (base_sum + (CNT_W+1)'(1) < {1'b0, n_reg}) begin
                        base_next   = base_sum[CNT_W-1:0];
                        rd_idx_next = base_sum[CNT_W-1:0];
                        clear_cells = 1'b1;
                        state_next  = ST_STREAM;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_best_next  = global_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            global_reg.found <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_valid_reg     <= rd_en;
            out_valid_reg    <= out_valid_next;
            global_reg.found <= global_next.found;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg              <= n_next;
        base_reg           <= base_next;
        rd_idx_reg         <= rd_idx_next;
        phase_reg          <= phase_next;
        global_reg.sq_dist <= global_next.sq_dist;
        global_reg.id_a    <= global_next.id_a;
        global_reg.id_b    <= global_next.id_b;
        out_best_reg       <= out_best_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_best_reg.id_b,
                       out_best_reg.id_a, out_best_reg.sq_dist};
    assign m_tuser  = out_best_reg.found;

    `CPOP_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "point count beyond store depth")
    `CPOP_ASSERT_IMPL(a_search_two, aclk, aresetn, state_reg == ST_STREAM, n_reg > CNT_W'(1), "search started with fewer than two points")
    `CPOP_ASSERT_IMPL(a_read_bound, aclk, aresetn, state_reg == ST_STREAM, rd_idx_reg < n_reg, "read beyond the loaded points")
    `CPOP_ASSERT_IMPL(a_no_pair_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "result without a pair carries data")
    `CPOP_ASSERT_NEXT(a_count_restart, aclk, aresetn, s_tvalid && s_tready && s_tlast, count_reg == '0, "point count not restarted after a set")

endmodule

`default_nettype wire

// ===== design/cpop_store.sv =====
// ----------------------------------------------------------------------------
// cpop_store
// point memory: one write port for loading, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpop_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [cpop_pkg::ADDR_W-1:0] wr_addr,
    input  cpop_pkg::cpop_point_t     wr_data,
    input  logic                      rd_en,
    input  logic [cpop_pkg::ADDR_W-1:0] rd_addr,
    output cpop_pkg::cpop_point_t     rd_data
);
    import cpop_pkg::*;

    cpop_point_t mem [MAX_POINTS];
    cpop_point_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/cpop_cell.sv =====
// ----------------------------------------------------------------------------
// cpop_cell
// one search cell: takes the first free point of the stream as its own,
// then measures every later point against it and keeps the closest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpop_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  cpop_pkg::cpop_stream_t stream_in,
    output cpop_pkg::cpop_stream_t stream_out,
    input  cpop_pkg::cpop_best_t   red_in,
    output cpop_pkg::cpop_best_t   red_out
);
    import cpop_pkg::*;

    logic         own_valid_reg, own_valid_next;
    cpop_point_t  own_pt_reg;
    cpop_stream_t fwd_reg, fwd_next;
    logic         capture, compare;

    logic [COORD_W:0]   dx, dy, dx_neg, dy_neg;
    logic [COORD_W-1:0] adx, ady;

    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_adx_reg, s1_ady_reg;
    logic [ID_W-1:0]    s1_id_reg;
    logic               s2_valid_reg;
    logic [SQ_W-1:0]    s2_sqx_reg, s2_sqy_reg;
    logic [ID_W-1:0]    s2_id_reg;
    logic               s3_valid_reg;
    logic [DIST_W-1:0]  s3_dist_reg;
    logic [ID_W-1:0]    s3_id_reg;

    cpop_best_t best_reg, best_next;
    cpop_best_t red_reg, red_next;

    assign capture = stream_in.valid && !stream_in.taken && !own_valid_reg;
    assign compare = stream_in.valid && !stream_in.taken && own_valid_reg;

    assign dx     = {stream_in.pt.x[COORD_W-1], stream_in.pt.x}
                  - {own_pt_reg.x[COORD_W-1], own_pt_reg.x};
    assign dy     = {stream_in.pt.y[COORD_W-1], stream_in.pt.y}
                  - {own_pt_reg.y[COORD_W-1], own_pt_reg.y};
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    // a difference of two 31-bit values has a magnitude that fits 31 bits
    assign adx    = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    assign ady    = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];

    always_comb begin
        fwd_next       = stream_in;
        fwd_next.taken = stream_in.taken | capture;
        own_valid_next = clear ? 1'b0 : (own_valid_reg | capture);
    end

    // strict less keeps the earliest later point on a tie
    always_comb begin
        best_next = best_reg;
        if (clear) begin
            best_next.found = 1'b0;
        end else if (s3_valid_reg && (!best_reg.found || s3_dist_reg < best_reg.sq_dist)) begin
            best_next.found   = 1'b1;
            best_next.sq_dist = s3_dist_reg;
            best_next.id_a    = own_pt_reg.id;
            best_next.id_b    = s3_id_reg;
        end
    end

    // the value from the left belongs to lower indices and wins a tie
    always_comb begin
        if (best_reg.found && (!red_in.found || best_reg.sq_dist < red_in.sq_dist)) begin
            red_next = best_reg;
        end else begin
            red_next = red_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_valid_reg  <= 1'b0;
            fwd_reg.valid  <= 1'b0;
            fwd_reg.taken  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_reg.found <= 1'b0;
            red_reg.found  <= 1'b0;
        end else begin
            own_valid_reg  <= own_valid_next;
            fwd_reg.valid  <= fwd_next.valid;
            fwd_reg.taken  <= fwd_next.taken;
            s1_valid_reg   <= compare;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            best_reg.found <= best_next.found;
            red_reg.found  <= red_next.found;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            own_pt_reg <= stream_in.pt;
        end
        fwd_reg.pt       <= fwd_next.pt;
        s1_adx_reg       <= adx;
        s1_ady_reg       <= ady;
        s1_id_reg        <= stream_in.pt.id;
        s2_sqx_reg       <= SQ_W'(s1_adx_reg) * SQ_W'(s1_adx_reg);
        s2_sqy_reg       <= SQ_W'(s1_ady_reg) * SQ_W'(s1_ady_reg);
        s2_id_reg        <= s1_id_reg;
        s3_dist_reg      <= DIST_W'(s2_sqx_reg) + DIST_W'(s2_sqy_reg);
        s3_id_reg        <= s2_id_reg;
        best_reg.sq_dist <= best_next.sq_dist;
        best_reg.id_a    <= best_next.id_a;
        best_reg.id_b    <= best_next.id_b;
        red_reg.sq_dist  <= red_next.sq_dist;
        red_reg.id_a     <= red_next.id_a;
        red_reg.id_b     <= red_next.id_b;
    end

    assign stream_out = fwd_reg;
    assign red_out    = red_reg;

endmodule

`default_nettype wire
